// ===== hw/rtl/cfp_pkg.sv =====
`timescale 1ns / 1ps

package cfp_pkg;

   localparam int BYTE_W    = 8;
   localparam int SEQ_W     = 16;
   localparam int PLEN_W    = 6;
   localparam int BIDX_W    = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_VER = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
   localparam logic [BYTE_W-1:0] EXP_VER_RST     = 8'h01;

   typedef enum logic [3:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_VER,
      PH_TYPE,
      PH_SEQ_LO,
      PH_SEQ_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_PAYLOAD,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_EMIT
   } phase_type;

   typedef struct packed {
      logic load_ver;
      logic load_type;
      logic load_seq_lo;
      logic load_seq_hi;
      logic load_len_lo;
      logic load_len_hi;
      logic store_byte;
      logic load_crc_lo;
      logic emit_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sync1_hit;
      logic sync2_hit;
      logic len_too_long;
      logic len_zero;
      logic fill_done;
      logic frame_good;
      logic emit_last;
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== hw/rtl/cfp_req_if.sv =====
`timescale 1ns / 1ps

interface cfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/cfp_rsp_if.sv =====
`timescale 1ns / 1ps

interface cfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_type;
   logic [15:0] sequence_res;
   logic [5:0]  payload_length;
   logic [4:0]  byte_index;
   logic [7:0]  payload_byte;
   logic        has_payload;
   logic        last;

   modport source (
      output valid, output frame_type, output sequence_res, output payload_length,
      output byte_index, output payload_byte, output has_payload, output last,
      input ready
   );
   modport sink (
      input valid, input frame_type, input sequence_res, input payload_length,
      input byte_index, input payload_byte, input has_payload, input last,
      output ready
   );
endinterface

// ===== hw/rtl/cfp_ctrl.sv =====
`timescale 1ns / 1ps

module cfp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cfp_pkg::ctrl_status_type status,
   output cfp_pkg::ctrl_cmd_type    cmd
);
   import cfp_pkg::*;

   phase_type state_ff;
   phase_type state_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_SYNC1;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PH_SYNC1: begin
            if (accept && status.sync1_hit) state_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (accept) state_in = status.sync2_hit ? PH_VER : PH_SYNC1;
         end
         PH_VER: begin
            if (accept) state_in = PH_TYPE;
         end
         PH_TYPE: begin
            if (accept) state_in = PH_SEQ_LO;
         end
         PH_SEQ_LO: begin
            if (accept) state_in = PH_SEQ_HI;
         end
         PH_SEQ_HI: begin
            if (accept) state_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (accept) state_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if (accept) begin
               if (status.len_too_long)  state_in = PH_SYNC1;
               else if (status.len_zero) state_in = PH_CRC_LO;
               else                      state_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (accept && status.fill_done) state_in = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            if (accept) state_in = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            if (accept) state_in = status.frame_good ? PH_EMIT : PH_SYNC1;
         end
         PH_EMIT: begin
            if (status.out_free && status.emit_last) state_in = PH_SYNC1;
         end
         default: begin
            state_in = PH_SYNC1;
         end
      endcase
   end

   // commands
   always_comb begin
      req_ready       = (state_ff != PH_EMIT);
      cmd             = '0;
      cmd.load_ver    = accept && (state_ff == PH_VER);
      cmd.load_type   = accept && (state_ff == PH_TYPE);
      cmd.load_seq_lo = accept && (state_ff == PH_SEQ_LO);
      cmd.load_seq_hi = accept && (state_ff == PH_SEQ_HI);
      cmd.load_len_lo = accept && (state_ff == PH_LEN_LO);
      cmd.load_len_hi = accept && (state_ff == PH_LEN_HI);
      cmd.store_byte  = accept && (state_ff == PH_PAYLOAD);
      cmd.load_crc_lo = accept && (state_ff == PH_CRC_LO);
      cmd.emit_load   = status.out_free && (state_ff == PH_EMIT);
   end

endmodule

// ===== hw/rtl/cfp_datapath.sv =====
`timescale 1ns / 1ps

module cfp_datapath #(
   parameter int PAYLOAD_LIMIT = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [cfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cfp_pkg::BYTE_W-1:0]      csr_write_data,
   input  logic [cfp_pkg::BYTE_W-1:0]      data_byte,
   input  cfp_pkg::ctrl_cmd_type           cmd,
   output cfp_pkg::ctrl_status_type        status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cfp_pkg::BYTE_W-1:0]      rsp_frame_type,
   output logic [cfp_pkg::SEQ_W-1:0]       rsp_sequence_res,
   output logic [cfp_pkg::PLEN_W-1:0]      rsp_payload_length,
   output logic [cfp_pkg::BIDX_W-1:0]      rsp_byte_index,
   output logic [cfp_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                            rsp_has_payload,
   output logic                            rsp_last
);
   import cfp_pkg::*;

   localparam int LEN_W  = $clog2(PAYLOAD_LIMIT + 1);
   localparam int ADDR_W = (PAYLOAD_LIMIT > 1) ? $clog2(PAYLOAD_LIMIT) : 1;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

   logic [BYTE_W-1:0] sync_first_ff;
   logic [BYTE_W-1:0] sync_second_ff;
   logic [BYTE_W-1:0] exp_ver_ff;

   logic [BYTE_W-1:0] held_ver_ff;
   logic [BYTE_W-1:0] held_type_ff;
   logic [SEQ_W-1:0]  held_seq_ff;
   logic [BYTE_W-1:0] len_lo_ff;
   logic [LEN_W-1:0]  held_len_ff;
   logic [LEN_W-1:0]  fill_ff;
   logic [LEN_W-1:0]  emit_ff;
   logic [15:0]       crc_ff;
   logic [15:0]       crc_in;
   logic [BYTE_W-1:0] crc_lo_ff;

   logic [BYTE_W-1:0] store_mem [PAYLOAD_LIMIT];

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_type_ff;
   logic [SEQ_W-1:0]  rsp_seq_ff;
   logic [PLEN_W-1:0] rsp_len_ff;
   logic [BIDX_W-1:0] rsp_idx_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_has_ff;
   logic              rsp_last_ff;

   logic [15:0]       len_full;
   logic [LEN_W-1:0]  fill_next;
   logic [LEN_W-1:0]  emit_next;
   logic              held_len_zero;

   assign len_full      = {data_byte, len_lo_ff};
   assign fill_next     = fill_ff + LEN_W'(1);
   assign emit_next     = emit_ff + LEN_W'(1);
   assign held_len_zero = (held_len_ff == '0);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         exp_ver_ff     <= EXP_VER_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_FIRST:   sync_first_ff  <= csr_write_data;
            CSR_SYNC_SECOND:  sync_second_ff <= csr_write_data;
            CSR_EXPECTED_VER: exp_ver_ff     <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // header capture and running CRC
   always_comb begin
      crc_in = crc_ff;
      if (cmd.load_ver) begin
         crc_in = crc_step(CRC_INIT, data_byte);
      end else if (cmd.load_type || cmd.load_seq_lo || cmd.load_seq_hi ||
                   cmd.load_len_lo || cmd.load_len_hi || cmd.store_byte) begin
         crc_in = crc_step(crc_ff, data_byte);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (cmd.load_ver)    held_ver_ff        <= data_byte;
      if (cmd.load_type)   held_type_ff       <= data_byte;
      if (cmd.load_seq_lo) held_seq_ff[7:0]   <= data_byte;
      if (cmd.load_seq_hi) held_seq_ff[15:8]  <= data_byte;
      if (cmd.load_len_lo) len_lo_ff          <= data_byte;
      if (cmd.load_len_hi) begin
         held_len_ff <= LEN_W'(len_full);
         fill_ff     <= '0;
         emit_ff     <= '0;
      end
      if (cmd.store_byte)  fill_ff   <= fill_next;
      if (cmd.load_crc_lo) crc_lo_ff <= data_byte;
      if (cmd.emit_load)   emit_ff   <= emit_next;
   end

   // payload buffer
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         store_mem[fill_ff[ADDR_W-1:0]] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_byte_ff <= store_mem[emit_ff[ADDR_W-1:0]];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_type_ff <= held_type_ff;
         rsp_seq_ff  <= held_seq_ff;
         rsp_len_ff  <= PLEN_W'(held_len_ff);
         rsp_idx_ff  <= BIDX_W'(emit_ff);
         rsp_has_ff  <= !held_len_zero;
         rsp_last_ff <= status.emit_last;
      end
   end

   always_comb begin
      status              = '0;
      status.sync1_hit    = (data_byte == sync_first_ff);
      status.sync2_hit    = (data_byte == sync_second_ff);
      status.len_too_long = (len_full > 16'(PAYLOAD_LIMIT));
      status.len_zero     = (len_full == 16'd0);
      status.fill_done    = (fill_next == held_len_ff);
      status.frame_good   = ({data_byte, crc_lo_ff} == crc_ff) && (held_ver_ff == exp_ver_ff);
      status.emit_last    = held_len_zero || (emit_next == held_len_ff);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_type     = rsp_type_ff;
   assign rsp_sequence_res   = rsp_seq_ff;
   assign rsp_payload_length = rsp_len_ff;
   assign rsp_byte_index     = rsp_idx_ff;
   assign rsp_payload_byte   = rsp_has_ff ? rsp_byte_ff : '0;
   assign rsp_has_payload    = rsp_has_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ===== hw/rtl/crc_checked_frame_parser.sv =====
`timescale 1ns / 1ps

// Frame parser for a byte stream: sync pair, version, type, sequence (LE16),
// length (LE16), payload and a LE16 CRC-16/CCITT over header and payload.
// req_if carries one received byte per item; rsp_if carries one payload byte
// per item with the header fields repeated, or a single no-payload item with
// last set for an empty frame. Bad frames (CRC, version, oversize length)
// give nothing. The csr_ port writes sync_first, sync_second and
// expected_version; write it only while the parser is idle.
// Throughput: one received byte per cycle while a frame is being read. After
// the CRC high byte of a good frame, req_if.ready drops while the payload
// buffer is read out, one item per cycle from its single read port while
// rsp_if does not stall. Readout: after the CRC high byte is accepted, the
// sequencer enters its emit state, which loads the first result into the
// result register once that register is free. A stall on rsp_if holds the
// result register and the readout; once the last item sits in the register
// the next frame's bytes are taken.
// Reset: synchronous, active high; the parser hunts for the first sync byte,
// the registers return to 0xAA, 0x55 and version 1, and no result is pending.
module crc_checked_frame_parser #(
   parameter int PAYLOAD_LIMIT = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   cfp_req_if.sink                       req_if,
   cfp_rsp_if.source                     rsp_if,
   input  logic                          csr_write_enable,
   input  logic [cfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfp_pkg::BYTE_W-1:0]    csr_write_data
);
   import cfp_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: walks the frame fields and the readout
   cfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // header registers, CRC, payload buffer and result register
   cfp_datapath #(
      .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .data_byte          (req_if.data_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_frame_type     (rsp_if.frame_type),
      .rsp_sequence_res   (rsp_if.sequence_res),
      .rsp_payload_length (rsp_if.payload_length),
      .rsp_byte_index     (rsp_if.byte_index),
      .rsp_payload_byte   (rsp_if.payload_byte),
      .rsp_has_payload    (rsp_if.has_payload),
      .rsp_last           (rsp_if.last)
   );

endmodule

// ===== hw/rtl/cfp_checker.sv =====
`timescale 1ns / 1ps

module cfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_frame_type,
   input logic [15:0] rsp_sequence_res,
   input logic [5:0]  rsp_payload_length,
   input logic [4:0]  rsp_byte_index,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_has_payload,
   input logic        rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_index) &&
      $stable(rsp_payload_byte) && $stable(rsp_last) && $stable(rsp_sequence_res) &&
      $stable(rsp_frame_type))
      else $error("result changed while stalled");

   // no input taken while a frame's readout is unfinished
   a_no_input_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready during payload readout");

   // an empty frame gives one zeroed, final item
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_payload |-> rsp_last && rsp_byte_index == 5'd0 &&
      rsp_payload_byte == 8'd0 && rsp_payload_length == 6'd0)
      else $error("malformed empty-frame item");

   // the final payload item sits at the last index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_payload && rsp_last |->
      rsp_byte_index == 5'(rsp_payload_length - 6'd1))
      else $error("last flag on wrong index");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind crc_checked_frame_parser cfp_checker u_cfp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_frame_type     (rsp_if.frame_type),
   .rsp_sequence_res   (rsp_if.sequence_res),
   .rsp_payload_length (rsp_if.payload_length),
   .rsp_byte_index     (rsp_if.byte_index),
   .rsp_payload_byte   (rsp_if.payload_byte),
   .rsp_has_payload    (rsp_if.has_payload),
   .rsp_last           (rsp_if.last)
);

// ===== verif/crc_checked_frame_parser_tb.sv =====
`timescale 1ns / 1ps

module crc_checked_frame_parser_tb;
   import cfp_pkg::*;

   localparam int PAYLOAD_MAX      = 32;
   localparam int LONG_HOLD_CYCLES = 300;   // receiver hold-off used to back up the parser
   localparam int SETTLE_CYCLES    = 8;     // lets the parser settle after a drain
   localparam int DRAIN_LIMIT      = 20000;
   localparam int MAX_REPORTS      = 10;

   // Index 3 decodes to no register; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   // One payload item as it leaves the parser.
   typedef struct packed {
      logic [BYTE_W-1:0] frame_type;
      logic [SEQ_W-1:0]  sequence_res;
      logic [PLEN_W-1:0] payload_length;
      logic [BIDX_W-1:0] byte_index;
      logic [BYTE_W-1:0] payload_byte;
      logic              has_payload;
      logic              last;
   } payload_item_type;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_CRC,
      FRAME_BAD_VERSION,
      FRAME_OVERSIZE,
      FRAME_BAD_SYNC,
      FRAME_NOISE
   } frame_kind_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_write_data;

   cfp_req_if req_ch ();
   cfp_rsp_if rsp_ch ();

   crc_checked_frame_parser #(
      .PAYLOAD_LIMIT(PAYLOAD_MAX)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register values the parser should hold; change only while it is idle.
   logic [BYTE_W-1:0] cfg_sync_first;
   logic [BYTE_W-1:0] cfg_sync_second;
   logic [BYTE_W-1:0] cfg_version;

   // Mirror of the parser's own state, advanced once per accepted byte.
   phase_type         rx_phase;
   logic [BYTE_W-1:0] hdr_version;
   logic [BYTE_W-1:0] hdr_type;
   logic [SEQ_W-1:0]  hdr_seq;
   logic [15:0]       hdr_len;
   int                fill_count;
   logic [15:0]       rx_crc;
   logic [BYTE_W-1:0] crc_low_byte;
   logic [BYTE_W-1:0] payload_copy [PAYLOAD_MAX];

   logic [BYTE_W-1:0] pending_bytes [$];   // bytes waiting to be offered
   payload_item_type  due_items [$];       // payload items the parser still owes

   int bytes_queued;
   int bytes_accepted;
   int frames_queued;
   int items_checked;
   int frame_ends_seen;
   int settings_used;
   int fail_count;

   int sender_idle_pct;
   int recv_stall_pct;
   int long_hold_asks;    // bumped by the sequence to request a hold-off
   int long_hold_taken;   // owned by the receiver process
   int hold_left;

   // CRC-16, polynomial 0x1021, MSB first, one byte at a time.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [BYTE_W-1:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic void log_failure(input string what, input payload_item_type want,
                                       input payload_item_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("[%0t] MISMATCH %s", $realtime, what);
         $display("   want type=%02h seq=%04h len=%0d idx=%0d byte=%02h has=%0b last=%0b",
                  want.frame_type, want.sequence_res, want.payload_length, want.byte_index,
                  want.payload_byte, want.has_payload, want.last);
         $display("   got  type=%02h seq=%04h len=%0d idx=%0d byte=%02h has=%0b last=%0b",
                  got.frame_type, got.sequence_res, got.payload_length, got.byte_index,
                  got.payload_byte, got.has_payload, got.last);
      end
   endfunction

   // Advance the parser mirror by one received byte; queue the payload items a
   // good frame releases when its CRC high byte arrives.
   task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
      payload_item_type item;
      logic [15:0]      wire_crc;
      case (rx_phase)
         PH_SYNC1: begin
            if (b == cfg_sync_first) rx_phase = PH_SYNC2;
         end
         PH_SYNC2: begin
            // a wrong byte here is not retried as a first sync byte
            rx_phase = (b == cfg_sync_second) ? PH_VER : PH_SYNC1;
         end
         PH_VER: begin
            hdr_version = b;
            hdr_type    = '0;
            hdr_seq     = '0;
            hdr_len     = '0;
            rx_crc      = crc16_byte(CRC_INIT, b);
            rx_phase    = PH_TYPE;
         end
         PH_TYPE: begin
            hdr_type = b;
            rx_crc   = crc16_byte(rx_crc, b);
            rx_phase = PH_SEQ_LO;
         end
         PH_SEQ_LO: begin
            hdr_seq[7:0] = b;
            rx_crc       = crc16_byte(rx_crc, b);
            rx_phase     = PH_SEQ_HI;
         end
         PH_SEQ_HI: begin
            hdr_seq[15:8] = b;
            rx_crc        = crc16_byte(rx_crc, b);
            rx_phase      = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            hdr_len[7:0] = b;
            rx_crc       = crc16_byte(rx_crc, b);
            rx_phase     = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            hdr_len[15:8] = b;
            rx_crc        = crc16_byte(rx_crc, b);
            fill_count    = 0;
            // drop an oversize frame right after its length
            if (hdr_len > PAYLOAD_MAX) rx_phase = PH_SYNC1;
            else if (hdr_len == 0) rx_phase = PH_CRC_LO;
            else rx_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            payload_copy[fill_count] = b;
            fill_count++;
            rx_crc = crc16_byte(rx_crc, b);
            if (fill_count >= hdr_len) rx_phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crc_low_byte = b;
            rx_phase     = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            wire_crc = {b, crc_low_byte};
            rx_phase = PH_SYNC1;
            if (wire_crc == rx_crc && hdr_version == cfg_version) begin
               item.frame_type   = hdr_type;
               item.sequence_res = hdr_seq;
               if (hdr_len == 0) begin
                  // empty frame: one marker item, no payload
                  item.payload_length = '0;
                  item.byte_index     = '0;
                  item.payload_byte   = '0;
                  item.has_payload    = 1'b0;
                  item.last           = 1'b1;
                  due_items.push_back(item);
               end else begin
                  for (int i = 0; i < hdr_len; i++) begin
                     item.payload_length = hdr_len[PLEN_W-1:0];
                     item.byte_index     = BIDX_W'(i);
                     item.payload_byte   = payload_copy[i];
                     item.has_payload    = 1'b1;
                     item.last           = (i == hdr_len - 1);
                     due_items.push_back(item);
                  end
               end
            end
         end
         default: rx_phase = PH_SYNC1;
      endcase
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   // Queue a whole frame with the current sync pair. Stop after the length for
   // an oversize frame; flip CRC bits by crc_flip to spoil it on purpose.
   task automatic queue_frame(input logic [BYTE_W-1:0] version, input logic [BYTE_W-1:0] ftype,
                              input logic [15:0] seq, input logic [15:0] len,
                              input logic [15:0] crc_flip);
      logic [BYTE_W-1:0] hdr [6];
      logic [BYTE_W-1:0] b;
      logic [15:0]       crc;
      frames_queued++;
      push_byte(cfg_sync_first);
      push_byte(cfg_sync_second);
      hdr = '{version, ftype, seq[7:0], seq[15:8], len[7:0], len[15:8]};
      crc = CRC_INIT;
      foreach (hdr[i]) begin
         push_byte(hdr[i]);
         crc = crc16_byte(crc, hdr[i]);
      end
      if (len > PAYLOAD_MAX) return;
      for (int i = 0; i < len; i++) begin
         b = BYTE_W'($urandom);
         push_byte(b);
         crc = crc16_byte(crc, b);
      end
      crc = crc ^ crc_flip;
      push_byte(crc[7:0]);
      push_byte(crc[15:8]);
   endtask

   // Mostly short payloads; the full buffer now and then.
   function automatic logic [15:0] pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 16'($urandom_range(0, 4));
      if (roll < 90) return 16'($urandom_range(5, PAYLOAD_MAX - 1));
      return 16'(PAYLOAD_MAX);
   endfunction

   task automatic queue_random_frame();
      int                roll;
      frame_kind_type    kind;
      logic [15:0]       len;
      logic [BYTE_W-1:0] b;
      roll = $urandom_range(0, 99);
      if (roll < 60) kind = FRAME_GOOD;
      else if (roll < 70) kind = FRAME_BAD_CRC;
      else if (roll < 80) kind = FRAME_BAD_VERSION;
      else if (roll < 88) kind = FRAME_OVERSIZE;
      else if (roll < 94) kind = FRAME_BAD_SYNC;
      else kind = FRAME_NOISE;
      len = pick_length();
      case (kind)
         FRAME_GOOD: begin
            queue_frame(cfg_version, BYTE_W'($urandom), SEQ_W'($urandom), len, '0);
         end
         FRAME_BAD_CRC: begin
            queue_frame(cfg_version, BYTE_W'($urandom), SEQ_W'($urandom), len,
                        16'($urandom_range(1, 16'hFFFF)));
         end
         FRAME_BAD_VERSION: begin
            queue_frame(cfg_version ^ BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom),
                        SEQ_W'($urandom), len, '0);
         end
         FRAME_OVERSIZE: begin
            if ($urandom_range(0, 1) == 0) len = 16'(PAYLOAD_MAX + 1);
            else len = 16'($urandom_range(PAYLOAD_MAX + 1, 16'hFFFF));
            queue_frame(cfg_version, BYTE_W'($urandom), SEQ_W'($urandom), len, '0);
         end
         FRAME_BAD_SYNC: begin
            // first sync byte, then a wrong second one
            push_byte(cfg_sync_first);
            b = (cfg_sync_first != cfg_sync_second) ? cfg_sync_first : ~cfg_sync_second;
            push_byte(b);
         end
         FRAME_NOISE: begin
            // line noise that never looks like a first sync byte
            repeat ($urandom_range(1, 4)) begin
               b = BYTE_W'($urandom);
               if (b == cfg_sync_first) b = b ^ 8'h01;
               push_byte(b);
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_random_bytes(input int target);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < target) queue_random_frame();
   endtask

   // Wait until every queued byte is taken and every due item has come back,
   // then let the parser settle.
   task automatic wait_for_drain();
      int waited;
      waited = 0;
      while ((bytes_accepted != bytes_queued || due_items.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back, plus a stray write to the unused
   // index; hold the write enable high across the burst.
   task automatic apply_settings(input logic [BYTE_W-1:0] sync_a, input logic [BYTE_W-1:0] sync_b,
                                 input logic [BYTE_W-1:0] version);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SYNC_FIRST;
      csr_write_data   <= sync_a;
      @(posedge clock);
      csr_index        <= CSR_SYNC_SECOND;
      csr_write_data   <= sync_b;
      @(posedge clock);
      csr_index        <= CSR_EXPECTED_VER;
      csr_write_data   <= version;
      @(posedge clock);
      csr_index        <= CSR_UNUSED_IDX;
      csr_write_data   <= BYTE_W'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      cfg_sync_first  = sync_a;
      cfg_sync_second = sync_b;
      cfg_version     = version;
      settings_used++;
   endtask

   always #5 clock = ~clock;

   // Sender: feed the pending bytes, mirror the parser on every accepted one.
   // Hold data steady while valid waits for ready.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= '0;
         rx_phase         = PH_SYNC1;
         hdr_version      = '0;
         hdr_type         = '0;
         hdr_seq          = '0;
         hdr_len          = '0;
         fill_count       = 0;
         rx_crc           = CRC_INIT;
         crc_low_byte     = '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            track_rx_byte(req_ch.data_byte);
            bytes_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= pending_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted item against the oldest one due, and stall
   // at random or for a long hold-off when the sequence asks for one.
   always @(posedge clock) begin
      payload_item_type got;
      payload_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.frame_type, rsp_ch.sequence_res, rsp_ch.payload_length,
                   rsp_ch.byte_index, rsp_ch.payload_byte, rsp_ch.has_payload, rsp_ch.last};
            items_checked++;
            if (got.last) frame_ends_seen++;
            if (due_items.size() == 0) begin
               log_failure("item with none due", '0, got);
            end else begin
               want = due_items.pop_front();
               if (got !== want) log_failure("wrong field", want, got);
            end
         end
         if (long_hold_taken != long_hold_asks) begin
            long_hold_taken = long_hold_asks;
            hold_left       = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Run limit: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SYNC_FIRST;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      cfg_sync_first   = SYNC_FIRST_RST;
      cfg_sync_second  = SYNC_SECOND_RST;
      cfg_version      = EXP_VER_RST;
      sender_idle_pct  = 0;
      recv_stall_pct   = 0;
      long_hold_asks   = 0;
      long_hold_taken  = 0;
      bytes_queued     = 0;
      bytes_accepted   = 0;
      frames_queued    = 0;
      items_checked    = 0;
      frame_ends_seen  = 0;
      settings_used    = 1;
      fail_count       = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed, reset register values, no idling.
      // Empty frame with the widest type and sequence: one marker item.
      queue_frame(cfg_version, 8'hFF, 16'hFFFF, 16'd0, '0);
      // Wrong second sync byte equal to the first one: not taken as a new start.
      push_byte(cfg_sync_first);
      push_byte(cfg_sync_first);
      // Largest length on the wire: dropped after the length bytes.
      queue_frame(cfg_version, 8'h00, 16'h0000, 16'hFFFF, '0);
      // Wrong version with a good CRC: dropped.
      queue_frame(cfg_version ^ 8'h80, 8'h5A, 16'h1234, 16'd0, '0);
      wait_for_drain();

      // Zero first sync, all-ones second sync and version. Hold the receiver off
      // for a long stretch while a full-buffer frame and more bytes come in, so
      // the parser backs up and stalls its input.
      apply_settings(8'h00, 8'hFF, 8'hFF);
      long_hold_asks++;
      queue_frame(cfg_version, BYTE_W'($urandom), SEQ_W'($urandom), 16'(PAYLOAD_MAX), '0);
      queue_random_bytes(6);
      wait_for_drain();

      // Swapped extremes, version zero; sender idles often.
      apply_settings(8'hFF, 8'h00, 8'h00);
      sender_idle_pct = 63;
      queue_random_bytes(8);
      wait_for_drain();

      // Random register values; receiver stalls often.
      apply_settings(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      sender_idle_pct = 0;
      recv_stall_pct  = 63;
      queue_random_bytes(8);
      wait_for_drain();

      // Back to the reset values; both sides idle.
      apply_settings(SYNC_FIRST_RST, SYNC_SECOND_RST, EXP_VER_RST);
      sender_idle_pct = 38;
      recv_stall_pct  = 38;
      queue_random_bytes(8);
      wait_for_drain();

      if (due_items.size() != 0) begin
         $display("%0d payload items never arrived", due_items.size());
         fail_count += due_items.size();
      end
      if (bytes_accepted != bytes_queued) begin
         $display("%0d queued bytes never taken", bytes_queued - bytes_accepted);
         fail_count++;
      end

      $display("Sent %0d bytes in %0d frames under %0d register settings",
               bytes_accepted, frames_queued, settings_used);
      $display("Checked %0d payload items closing %0d frames; %0d failures",
               items_checked, frame_ends_seen, fail_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
